### rtl/core/smv_pkg.sv
// ----------------------------------------------------------------------------
// smv_pkg
// Shared types and constants of the sample mean / variance / min / max core.
// ----------------------------------------------------------------------------
package smv_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int VAR_W       = 32;
  localparam int COUNT_OUT_W = 17;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_MAX = 16'sh8000;

  // Sequencer of the finishing arithmetic. Each operation has a launch
  // state and a wait state.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_DIV_MEAN_W,
    ST_MUL_QN,
    ST_MUL_QN_W,
    ST_MUL_QT,
    ST_MUL_QT_W,
    ST_DIV_VAR,
    ST_DIV_VAR_W,
    ST_MUL_NM,
    ST_MUL_NM_W,
    ST_MUL_RR,
    ST_MUL_RR_W,
    ST_FINISH
  } back_state_t;

endpackage

### rtl/core/smv_queue.sv
// ----------------------------------------------------------------------------
// smv_queue
// Short first-in first-out queue carrying set totals from front to back.
// ----------------------------------------------------------------------------
module smv_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  localparam int DEPTH = smv_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/core/smv_front.sv
// ----------------------------------------------------------------------------
// smv_front
// Accumulates count, sum, sum of squares, minimum and maximum of a set, one
// sample per cycle unless the queue is full, and queues each set's totals.
// ----------------------------------------------------------------------------
module smv_front #(
  parameter int MAX_SAMPLES = 65536,
  parameter int CW          = $clog2(MAX_SAMPLES + 1),
  parameter int SW          = smv_pkg::SAMPLE_W + CW,
  parameter int QW          = 30 + CW,
  parameter int SNAP_W      = 1 + 2 * smv_pkg::SAMPLE_W + QW + SW + CW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  input  logic signed [smv_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last,
  input  logic                                q_full,
  output logic                                q_push,
  output logic [SNAP_W-1:0]                   q_wdata
);

  typedef struct packed {
    logic                                ovf;
    logic signed [smv_pkg::SAMPLE_W-1:0] max;
    logic signed [smv_pkg::SAMPLE_W-1:0] min;
    logic [QW-1:0]                       sq;
    logic signed [SW-1:0]                sum;
    logic [CW-1:0]                       cnt;
  } snap_t;

  logic [CW-1:0]                       cnt_r, cnt_nxt;
  logic signed [SW-1:0]                sum_r, sum_nxt;
  logic [QW-1:0]                       sq_r, sq_nxt;
  logic signed [smv_pkg::SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [smv_pkg::SAMPLE_W-1:0] max_r, max_nxt;
  logic                                ovf_r, ovf_nxt;
  logic signed [31:0]                  square;
  logic                                accept;
  logic                                room;
  snap_t                               snap;

  assign accept = in_push && !q_full;
  assign room   = (cnt_r < CW'(MAX_SAMPLES));
  assign square = in_sample * in_sample;

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    min_nxt = min_r;
    max_nxt = max_r;
    ovf_nxt = ovf_r;
    if (room) begin
      cnt_nxt = cnt_r + CW'(1);
      sum_nxt = sum_r + SW'(in_sample);
      sq_nxt  = sq_r + QW'(square[30:0]);
      if (in_sample < min_r) begin
        min_nxt = in_sample;
      end
      if (in_sample > max_r) begin
        max_nxt = in_sample;
      end
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  // The totals including the final sample go straight into the queue.
  always_comb begin
    snap.ovf = ovf_nxt;
    snap.max = max_nxt;
    snap.min = min_nxt;
    snap.sq  = sq_nxt;
    snap.sum = sum_nxt;
    snap.cnt = cnt_nxt;
  end

  assign q_wdata = snap;
  assign q_push  = accept && in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      min_r <= smv_pkg::SAMPLE_POS_MAX;
      max_r <= smv_pkg::SAMPLE_NEG_MAX;
      ovf_r <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        cnt_r <= '0;
        sum_r <= '0;
        sq_r  <= '0;
        min_r <= smv_pkg::SAMPLE_POS_MAX;
        max_r <= smv_pkg::SAMPLE_NEG_MAX;
        ovf_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
        sq_r  <= sq_nxt;
        min_r <= min_nxt;
        max_r <= max_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

endmodule

### rtl/core/smv_mul.sv
// ----------------------------------------------------------------------------
// smv_mul
// Unsigned shift-and-add multiplier, one bit of operand b per cycle, most
// significant bit first.
// ----------------------------------------------------------------------------
module smv_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic               done,
  output logic [AW+BW-1:0]   prod
);

  localparam int PW    = AW + BW;
  localparam int CNT_W = $clog2(BW + 1);

  logic [AW-1:0]    a_r;
  logic [BW-1:0]    b_r;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  assign prod_nxt = {prod_r[PW-2:0], 1'b0} + (b_r[BW-1] ? PW'(a_r) : '0);
  assign prod     = prod_r;
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      prod_r <= '0;
    end else if (busy_r) begin
      b_r    <= {b_r[BW-2:0], 1'b0};
      prod_r <= prod_nxt;
    end
  end

endmodule

### rtl/core/smv_div.sv
// ----------------------------------------------------------------------------
// smv_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smv_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    div_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  // The partial remainder stays below the divisor, so the difference fits.
  assign trial   = {rem_r, quo_r[NW-1]};
  assign fits    = (trial >= {1'b0, div_r});
  assign diff    = trial - {1'b0, div_r};
  assign rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

endmodule

### rtl/core/smv_back.sv
// ----------------------------------------------------------------------------
// smv_back
// Turns the totals of one set into mean and unbiased variance with a shared
// serial divider and multiplier, and holds the result for the output side.
// ----------------------------------------------------------------------------
module smv_back #(
  parameter int MAX_SAMPLES = 65536,
  parameter int CW          = $clog2(MAX_SAMPLES + 1),
  parameter int SW          = smv_pkg::SAMPLE_W + CW,
  parameter int QW          = 30 + CW,
  parameter int SNAP_W      = 1 + 2 * smv_pkg::SAMPLE_W + QW + SW + CW
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  input  logic [SNAP_W-1:0]                      q_rdata,
  output logic                                   q_pop,
  input  logic                                   out_pop,
  output logic                                   out_empty,
  output logic signed [smv_pkg::SAMPLE_W-1:0]    out_mean,
  output logic [smv_pkg::VAR_W-1:0]              out_sample_variance,
  output logic signed [smv_pkg::SAMPLE_W-1:0]    out_minimum,
  output logic signed [smv_pkg::SAMPLE_W-1:0]    out_maximum,
  output logic [smv_pkg::COUNT_OUT_W-1:0]        out_sample_count,
  output logic                                   out_degenerate
);

  localparam int AW  = smv_pkg::SAMPLE_W - 1 + CW;  // magnitude of the sum
  localparam int MAW = smv_pkg::SAMPLE_W + CW;      // wide multiplier operand
  localparam int MBW = (CW > smv_pkg::SAMPLE_W) ? CW : smv_pkg::SAMPLE_W;
  localparam int PW  = MAW + MBW;
  localparam int SQ  = smv_pkg::SAMPLE_W;

  typedef struct packed {
    logic                 ovf;
    logic signed [SQ-1:0] max;
    logic signed [SQ-1:0] min;
    logic [QW-1:0]        sq;
    logic signed [SW-1:0] sum;
    logic [CW-1:0]        cnt;
  } snap_t;

  typedef struct packed {
    logic div_start;
    logic mul_start;
    logic res_load;
  } ctrl_t;

  smv_pkg::back_state_t state_r, state_nxt;
  ctrl_t                ctrl;
  snap_t                snap;

  logic [CW-1:0]        n_r;
  logic                 neg_r;
  logic [AW-1:0]        abs_r;
  logic [QW-1:0]        sq_r;
  logic signed [SQ-1:0] min_r;
  logic signed [SQ-1:0] max_r;
  logic                 ovf_r;
  logic [SQ-1:0]        q_r;
  logic [CW-1:0]        r_r;
  logic [MAW-1:0]       t_r;
  logic [QW-1:0]        a_r;
  logic [QW-1:0]        k_r;
  logic [CW-1:0]        m_r;
  logic [PW-1:0]        nm_r;
  logic [SW-1:0]        sum_neg;
  logic                 few;

  logic [QW-1:0]        div_dividend;
  logic [CW-1:0]        div_divisor;
  logic                 div_done;
  logic [QW-1:0]        div_quo;
  logic [CW-1:0]        div_rem;
  logic [MAW-1:0]       mul_a;
  logic [MBW-1:0]       mul_b;
  logic                 mul_done;
  logic [PW-1:0]        mul_prod;

  logic [PW-1:0]        sq_wide;
  logic [QW-1:0]        k_adj;
  logic [smv_pkg::VAR_W-1:0] var_fin;

  logic                            res_valid_r;
  logic signed [SQ-1:0]            res_mean_r;
  logic [smv_pkg::VAR_W-1:0]       res_var_r;
  logic signed [SQ-1:0]            res_min_r;
  logic signed [SQ-1:0]            res_max_r;
  logic [smv_pkg::COUNT_OUT_W-1:0] res_cnt_r;
  logic                            res_degen_r;

  assign snap    = q_rdata;
  assign sum_neg = -snap.sum;
  assign few     = (n_r < CW'(2));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smv_pkg::ST_IDLE: begin
        if (!q_empty) state_nxt = smv_pkg::ST_DIV_MEAN;
      end
      smv_pkg::ST_DIV_MEAN:   state_nxt = smv_pkg::ST_DIV_MEAN_W;
      smv_pkg::ST_DIV_MEAN_W: begin
        if (div_done) state_nxt = few ? smv_pkg::ST_FINISH : smv_pkg::ST_MUL_QN;
      end
      smv_pkg::ST_MUL_QN:     state_nxt = smv_pkg::ST_MUL_QN_W;
      smv_pkg::ST_MUL_QN_W: begin
        if (mul_done) state_nxt = smv_pkg::ST_MUL_QT;
      end
      smv_pkg::ST_MUL_QT:     state_nxt = smv_pkg::ST_MUL_QT_W;
      smv_pkg::ST_MUL_QT_W: begin
        if (mul_done) state_nxt = smv_pkg::ST_DIV_VAR;
      end
      smv_pkg::ST_DIV_VAR:    state_nxt = smv_pkg::ST_DIV_VAR_W;
      smv_pkg::ST_DIV_VAR_W: begin
        if (div_done) state_nxt = smv_pkg::ST_MUL_NM;
      end
      smv_pkg::ST_MUL_NM:     state_nxt = smv_pkg::ST_MUL_NM_W;
      smv_pkg::ST_MUL_NM_W: begin
        if (mul_done) state_nxt = smv_pkg::ST_MUL_RR;
      end
      smv_pkg::ST_MUL_RR:     state_nxt = smv_pkg::ST_MUL_RR_W;
      smv_pkg::ST_MUL_RR_W: begin
        if (mul_done) state_nxt = smv_pkg::ST_FINISH;
      end
      smv_pkg::ST_FINISH: begin
        if (!res_valid_r || out_pop) state_nxt = smv_pkg::ST_IDLE;
      end
      default: state_nxt = smv_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop          = 1'b0;
    ctrl           = '0;
    div_dividend   = QW'(abs_r);
    div_divisor    = n_r;
    mul_a          = MAW'(n_r);
    mul_b          = MBW'(q_r);
    unique case (state_r)
      smv_pkg::ST_IDLE:     q_pop = !q_empty;
      smv_pkg::ST_DIV_MEAN: ctrl.div_start = 1'b1;
      smv_pkg::ST_MUL_QN:   ctrl.mul_start = 1'b1;
      smv_pkg::ST_MUL_QT: begin
        ctrl.mul_start = 1'b1;
        mul_a          = t_r;
      end
      smv_pkg::ST_DIV_VAR: begin
        ctrl.div_start = 1'b1;
        div_dividend   = a_r;
        div_divisor    = n_r - CW'(1);
      end
      smv_pkg::ST_MUL_NM: begin
        ctrl.mul_start = 1'b1;
        mul_b          = MBW'(m_r);
      end
      smv_pkg::ST_MUL_RR: begin
        ctrl.mul_start = 1'b1;
        mul_a          = MAW'(r_r);
        mul_b          = MBW'(r_r);
      end
      smv_pkg::ST_FINISH:   ctrl.res_load = !res_valid_r || out_pop;
      default: begin
      end
    endcase
  end

  smv_div #(
    .NW (QW),
    .DW (CW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctrl.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  smv_mul #(
    .AW (MAW),
    .BW (MBW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign sq_wide = PW'(sq_r);

  // With |S| = q*n + r, the exact quotient is k, or k - 1 when n*m < r*r.
  // In the finishing state the multiplier still holds r*r.
  assign k_adj   = ((nm_r < mul_prod) && (k_r != '0)) ? k_r - QW'(1) : k_r;
  assign var_fin = few ? '0 :
                   (k_adj > QW'({smv_pkg::VAR_W{1'b1}})) ? {smv_pkg::VAR_W{1'b1}} :
                   k_adj[smv_pkg::VAR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smv_pkg::ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.res_load) begin
        res_valid_r <= 1'b1;
      end else if (out_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      n_r   <= snap.cnt;
      neg_r <= snap.sum[SW-1];
      abs_r <= snap.sum[SW-1] ? sum_neg[AW-1:0] : snap.sum[AW-1:0];
      sq_r  <= snap.sq;
      min_r <= snap.min;
      max_r <= snap.max;
      ovf_r <= snap.ovf;
    end
    if ((state_r == smv_pkg::ST_DIV_MEAN_W) && div_done) begin
      q_r <= (n_r == '0) ? '0 : div_quo[SQ-1:0];
      r_r <= div_rem;
    end
    if ((state_r == smv_pkg::ST_MUL_QN_W) && mul_done) begin
      t_r <= mul_prod[MAW-1:0] + MAW'({r_r, 1'b0});
    end
    if ((state_r == smv_pkg::ST_MUL_QT_W) && mul_done) begin
      a_r <= (sq_wide >= mul_prod) ? QW'(sq_wide - mul_prod) : '0;
    end
    if ((state_r == smv_pkg::ST_DIV_VAR_W) && div_done) begin
      k_r <= div_quo;
      m_r <= div_rem;
    end
    if ((state_r == smv_pkg::ST_MUL_NM_W) && mul_done) begin
      nm_r <= mul_prod;
    end
    if (ctrl.res_load) begin
      res_mean_r  <= neg_r ? -q_r : q_r;
      res_var_r   <= var_fin;
      res_min_r   <= min_r;
      res_max_r   <= max_r;
      res_cnt_r   <= smv_pkg::COUNT_OUT_W'(n_r);
      res_degen_r <= ovf_r || few;
    end
  end

  assign out_empty           = !res_valid_r;
  assign out_mean            = res_mean_r;
  assign out_sample_variance = res_var_r;
  assign out_minimum         = res_min_r;
  assign out_maximum         = res_max_r;
  assign out_sample_count    = res_cnt_r;
  assign out_degenerate      = res_degen_r;

endmodule

### rtl/core/sample_mean_variance_min_max_core.sv
// ----------------------------------------------------------------------------
// sample_mean_variance_min_max_core
// Mean, unbiased variance, minimum and maximum over sets of fixed-point
// samples.
// ----------------------------------------------------------------------------
// Samples are taken one per clock cycle while in_full is low. A front
// accumulator keeps count, sum, sum of squares, minimum and maximum; a
// transaction with in_last high closes the set and moves its totals into a
// two-entry queue. The back end works on one set at a time with a serial
// divider (one bit per cycle, QW = 30 + clog2(MAX_SAMPLES + 1) bits) and a
// serial multiplier (one bit per cycle over max(16, clog2(MAX_SAMPLES + 1))
// bits). These serial units set the rate of sets; in_full rises while the
// queue holds two finished sets. A finished result waits on the out_ ports
// while the next set is already worked on. Samples beyond MAX_SAMPLES in a
// set are dropped from the statistics and mark the result as degenerate.
module sample_mean_variance_min_max_core #(
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [smv_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [smv_pkg::SAMPLE_W-1:0] out_mean,
  output logic [smv_pkg::VAR_W-1:0]           out_sample_variance,
  output logic signed [smv_pkg::SAMPLE_W-1:0] out_minimum,
  output logic signed [smv_pkg::SAMPLE_W-1:0] out_maximum,
  output logic [smv_pkg::COUNT_OUT_W-1:0]     out_sample_count,
  output logic                                out_degenerate
);

  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int SW     = smv_pkg::SAMPLE_W + CW;
  localparam int QW     = 30 + CW;
  localparam int SNAP_W = 1 + 2 * smv_pkg::SAMPLE_W + QW + SW + CW;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [SNAP_W-1:0] q_wdata;
  logic [SNAP_W-1:0] q_rdata;

  assign in_full = q_full;

  smv_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CW          (CW),
    .SW          (SW),
    .QW          (QW),
    .SNAP_W      (SNAP_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_sample (in_sample),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  smv_queue #(
    .DW (SNAP_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  smv_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CW          (CW),
    .SW          (SW),
    .QW          (QW),
    .SNAP_W      (SNAP_W)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_rdata             (q_rdata),
    .q_pop               (q_pop),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_mean            (out_mean),
    .out_sample_variance (out_sample_variance),
    .out_minimum         (out_minimum),
    .out_maximum         (out_maximum),
    .out_sample_count    (out_sample_count),
    .out_degenerate      (out_degenerate)
  );

endmodule

### tb/sample_mean_variance_min_max_core_test.sv
// ----------------------------------------------------------------------------
// sample_mean_variance_min_max_core_test
// Self-checking testbench for the sample statistics core.
// ----------------------------------------------------------------------------
// Sets of samples are pushed through the input queue interface. Each accepted
// sample also feeds a behavioral accumulator in the testbench. When a set
// closes, the accumulator predicts the mean, unbiased variance, minimum,
// maximum, count and degenerate flag of the set. Every popped result is
// checked field by field against the oldest prediction. The run covers
// directed corner sets and random sets, while both sides of the block idle
// at random outside a steady stretch of the random sets.
// ----------------------------------------------------------------------------
module sample_mean_variance_min_max_core_test;

  typedef logic signed [smv_pkg::SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t                         mean;
    logic [smv_pkg::VAR_W-1:0]       variance;
    sample_t                         minimum;
    sample_t                         maximum;
    logic [smv_pkg::COUNT_OUT_W-1:0] count;
    logic                            degenerate;
  } set_stats_t;

  localparam int MAX_SAMPLES   = 65536;
  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_ITEMS  = 1700;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic                            in_full;
  sample_t                         in_sample = '0;
  logic                            in_last = 1'b0;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  sample_t                         out_mean;
  logic [smv_pkg::VAR_W-1:0]       out_sample_variance;
  sample_t                         out_minimum;
  sample_t                         out_maximum;
  logic [smv_pkg::COUNT_OUT_W-1:0] out_sample_count;
  logic                            out_degenerate;

  // While steady is set, neither side idles.
  bit          steady = 1'b0;
  int unsigned fault_count = 0;
  set_stats_t  pending_stats[$];

  int unsigned acc_count;
  longint      acc_sum;
  longint      acc_square_sum;
  sample_t     acc_min;
  sample_t     acc_max;
  bit          acc_overflow;

  always #6 clk = ~clk;

  sample_mean_variance_min_max_core #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_sample          (in_sample),
    .in_last            (in_last),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_mean           (out_mean),
    .out_sample_variance(out_sample_variance),
    .out_minimum        (out_minimum),
    .out_maximum        (out_maximum),
    .out_sample_count   (out_sample_count),
    .out_degenerate     (out_degenerate)
  );

  function automatic void clear_accumulator();
    acc_count      = 0;
    acc_sum        = 0;
    acc_square_sum = 0;
    acc_min        = smv_pkg::SAMPLE_POS_MAX;
    acc_max        = smv_pkg::SAMPLE_NEG_MAX;
    acc_overflow   = 1'b0;
  endfunction

  function automatic void accumulate_sample(sample_t s, logic last);
    longint     n;
    longint     spread;
    set_stats_t stats;
    if (acc_count < MAX_SAMPLES) begin
      acc_count++;
      acc_sum        += longint'(s);
      acc_square_sum += longint'(s) * longint'(s);
      if (s < acc_min) acc_min = s;
      if (s > acc_max) acc_max = s;
    end else begin
      acc_overflow = 1'b1;
    end
    if (last) begin
      n = acc_count;
      // Signed division truncates toward zero, as the mean requires.
      stats.mean       = sample_t'(acc_sum / n);
      stats.minimum    = acc_min;
      stats.maximum    = acc_max;
      stats.count      = n[smv_pkg::COUNT_OUT_W-1:0];
      stats.degenerate = acc_overflow || (n < 2);
      if (n < 2) begin
        stats.variance = '0;
      end else begin
        // The numerator is never negative and fits 63 bits for 16-bit samples.
        spread = (n * acc_square_sum - acc_sum * acc_sum) / (n * (n - 1));
        if (spread > 64'd4294967295) spread = 64'd4294967295;
        stats.variance = spread[smv_pkg::VAR_W-1:0];
      end
      pending_stats.push_back(stats);
      clear_accumulator();
    end
  endfunction

  function automatic void compare_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin
    set_stats_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_stats.size() == 0) begin
        $error("result transaction with no set pending");
        fault_count++;
      end else begin
        want = pending_stats.pop_front();
        compare_field("mean", want.mean, out_mean);
        compare_field("sample_variance", want.variance, out_sample_variance);
        compare_field("minimum", want.minimum, out_minimum);
        compare_field("maximum", want.maximum, out_maximum);
        compare_field("sample_count", want.count, out_sample_count);
        compare_field("degenerate", want.degenerate, out_degenerate);
      end
    end
    out_pop <= steady || ($urandom_range(99) >= 26);
  end

  // Returns right after the edge that accepted the transaction; in_push stays
  // high so that a following sample can go out without a gap.
  task automatic push_sample(sample_t s, logic last);
    while (!steady && $urandom_range(99) < 26) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push   <= 1'b1;
    in_sample <= s;
    in_last   <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    accumulate_sample(s, last);
  endtask

  task automatic wait_results_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_stats.size() != 0);
  endtask

  function automatic sample_t random_sample(int mode, sample_t center);
    case (mode)
      0: return sample_t'($urandom);
      1: return $urandom_range(1) ? smv_pkg::SAMPLE_POS_MAX : smv_pkg::SAMPLE_NEG_MAX;
      2: return sample_t'(int'(center) + int'($urandom_range(64)) - 32);
      default: return sample_t'(-int'($urandom_range(32768)));
    endcase
  endfunction

  task automatic test_single_sample_sets();
    push_sample(smv_pkg::SAMPLE_NEG_MAX, 1'b1);
    push_sample(smv_pkg::SAMPLE_POS_MAX, 1'b1);
    push_sample(sample_t'(0), 1'b1);
    push_sample(sample_t'(-1), 1'b1);
  endtask

  task automatic test_small_sets();
    // Widest spread of two samples gives the largest variance.
    push_sample(smv_pkg::SAMPLE_NEG_MAX, 1'b0);
    push_sample(smv_pkg::SAMPLE_POS_MAX, 1'b1);
    push_sample(smv_pkg::SAMPLE_POS_MAX, 1'b0);
    push_sample(smv_pkg::SAMPLE_POS_MAX, 1'b1);
    // Negative mean truncates toward zero.
    push_sample(sample_t'(-3), 1'b0);
    push_sample(sample_t'(0), 1'b1);
    // All samples negative: the maximum must be the largest negative sample.
    push_sample(sample_t'(-5), 1'b0);
    push_sample(sample_t'(-7), 1'b0);
    push_sample(sample_t'(-100), 1'b1);
    wait_results_drained();
    push_sample(sample_t'(100), 1'b0);
    push_sample(sample_t'(-1), 1'b0);
    push_sample(sample_t'(7), 1'b1);
    push_sample(smv_pkg::SAMPLE_NEG_MAX, 1'b0);
    push_sample(smv_pkg::SAMPLE_NEG_MAX, 1'b0);
    push_sample(smv_pkg::SAMPLE_NEG_MAX, 1'b1);
  endtask

  task automatic test_random_sets();
    int      sent;
    int      len;
    int      pick;
    int      mode;
    sample_t center;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (sent >= 600 && sent < 900);
      pick = $urandom_range(99);
      if (pick < 20) len = 1;
      else if (pick < 70) len = $urandom_range(8, 2);
      else if (pick < 95) len = $urandom_range(40, 9);
      else len = $urandom_range(200, 41);
      mode   = $urandom_range(3);
      center = sample_t'(int'($urandom_range(60000)) - 30000);
      for (int i = 0; i < len; i++)
        push_sample(random_sample(mode, center), i == len - 1);
      sent += len;
    end
    steady = 1'b0;
  endtask

  initial begin
    clear_accumulator();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_single_sample_sets();
    test_small_sets();
    test_random_sets();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
